// ===== hdl/hslc_pkg.sv =====
// hslc_pkg: types, constants and helper functions of the hsl colourise pixel block
`default_nettype none

package hslc_pkg;

    // pipeline and channel counts
    localparam int NUM_STG = 8;
    localparam int NUM_CH  = 3;
    localparam int CH_RED  = 0;
    localparam int CH_GRN  = 1;
    localparam int CH_BLU  = 2;

    // field widths
    localparam int PIX_W  = 8;
    localparam int HUE_W  = 9;
    localparam int SAT_W  = 7;
    localparam int LGT_W  = 8;
    localparam int CFG_W  = 9;
    localparam int LUM_W  = 17;
    localparam int PROD_W = 23;
    localparam int WGT_W  = 6;

    // q1.16 fixed point anchors
    localparam logic [LUM_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [LUM_W-1:0] HALF_Q16 = 17'd32768;

    // pixels below this alpha pass through as grey
    localparam logic [PIX_W-1:0] ALPHA_THRESHOLD = 8'd250;

    // percent and degree limits
    localparam logic [SAT_W-1:0] PCT_MAX  = 7'd100;
    localparam logic [HUE_W-1:0] DEG_FULL = 9'd360;
    localparam logic [HUE_W-1:0] DEG_60   = 9'd60;
    localparam logic [HUE_W-1:0] DEG_120  = 9'd120;
    localparam logic [HUE_W-1:0] DEG_180  = 9'd180;
    localparam logic [HUE_W-1:0] DEG_240  = 9'd240;

    // floor(x / 100) = (x * RECIP_100) >> 30, exact for x below 2^23
    localparam logic [23:0] RECIP_100 = 24'd10737419;
    localparam int          SHIFT_100 = 30;
    // floor(x / 60) = (x * RECIP_60) >> 28, exact for x below 2^22
    localparam logic [22:0] RECIP_60  = 23'd4473925;
    localparam int          SHIFT_60  = 28;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_HUE   = 2'd0,
        CFG_SAT   = 2'd1,
        CFG_LIGHT = 2'd2,
        CFG_NONE  = 2'd3
    } t_cfg_idx;

    // payloads of the pixel in and pixel out channels
    typedef struct packed {
        logic [PIX_W-1:0] intensity;
        logic [PIX_W-1:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] alpha_out;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix_out;

    // hue sector of one channel
    typedef enum logic [1:0] {
        SEC_RISE,
        SEC_HIGH,
        SEC_FALL,
        SEC_LOW
    } t_sec_mode;

    typedef struct packed {
        t_sec_mode        mode;
        logic [WGT_W-1:0] wgt;
    } t_sec;

    // sector and ramp weight for an angle 0..359
    function automatic t_sec hue_sector(input logic [HUE_W-1:0] d);
        t_sec             res;
        logic [HUE_W-1:0] fall;
        fall = DEG_240 - d;
        if (d < DEG_60) begin
            res.mode = SEC_RISE;
            res.wgt  = d[WGT_W-1:0];
        end else if (d < DEG_180) begin
            res.mode = SEC_HIGH;
            res.wgt  = '0;
        end else if (d < DEG_240) begin
            res.mode = SEC_FALL;
            res.wgt  = fall[WGT_W-1:0];
        end else begin
            res.mode = SEC_LOW;
            res.wgt  = '0;
        end
        return res;
    endfunction

    // angle plus offset, wrapped below 360
    function automatic logic [HUE_W-1:0] hue_add(input logic [HUE_W-1:0] h,
                                                 input logic [HUE_W-1:0] ofs);
        logic [HUE_W:0] sum;
        logic [HUE_W:0] wrap;
        sum  = {1'b0, h} + {1'b0, ofs};
        wrap = sum - {1'b0, DEG_FULL};
        return (sum >= {1'b0, DEG_FULL}) ? wrap[HUE_W-1:0] : sum[HUE_W-1:0];
    endfunction

    // q1.16 value to byte, v * 255 >> 16 with v held at 1.0
    function automatic logic [PIX_W-1:0] to_byte(input logic [LUM_W-1:0] v);
        logic [LUM_W-1:0]       vc;
        logic [LUM_W+PIX_W-1:0] t;
        vc = (v > ONE_Q16) ? ONE_Q16 : v;
        t  = {vc, 8'b0} - {8'b0, vc};
        return t[23:16];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hsl_colourise_pixel.sv =====
// hsl_colourise_pixel: eight stage pipeline that colourises intensity-alpha pixels
//
//  channel   direction   handshake           payload
//  pixel in  input       i_valid / o_stall   i_pix  (intensity, alpha_in)
//  pixel out output      o_valid / i_stall   o_pix  (alpha_out, red, green, blue)
//  config    input       i_cfg_we            i_cfg_idx, i_cfg_data
//
// one pixel per clock sustained while i_stall is low
// the eight register stages each hold at most one multiply, with adds, clamps and selects around it
// every stage keeps its own valid bit, so bubbles are squeezed out under stall
// o_stall rises only when all eight stages hold pixels and i_stall is high
// synchronous active-low reset clears the stage valid bits and the config registers
`default_nettype none

module hsl_colourise_pixel (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire hslc_pkg::t_pix_in          i_pix,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output hslc_pkg::t_pix_out              o_pix,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [hslc_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int LW = hslc_pkg::LUM_W;
    localparam int PW = hslc_pkg::PROD_W;
    localparam int NS = hslc_pkg::NUM_STG;
    localparam int NC = hslc_pkg::NUM_CH;

    // configuration registers
    logic [hslc_pkg::HUE_W-1:0] r_hue;
    logic [hslc_pkg::SAT_W-1:0] r_sat;
    logic [hslc_pkg::LGT_W-1:0] r_light;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue   <= '0;
            r_sat   <= '0;
            r_light <= '0;
        end else if (i_cfg_we) begin
            unique case (hslc_pkg::t_cfg_idx'(i_cfg_idx))
                hslc_pkg::CFG_HUE:   r_hue   <= i_cfg_data[hslc_pkg::HUE_W-1:0];
                hslc_pkg::CFG_SAT:   r_sat   <= i_cfg_data[hslc_pkg::SAT_W-1:0];
                hslc_pkg::CFG_LIGHT: r_light <= i_cfg_data[hslc_pkg::LGT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped config and per-channel hue sectors
    logic                       lp_pos;
    logic                       lp_neg;
    logic [hslc_pkg::SAT_W-1:0] lp_mag;
    logic [hslc_pkg::SAT_W-1:0] lp_negf;
    logic [hslc_pkg::SAT_W-1:0] sat_c;
    logic [hslc_pkg::HUE_W-1:0] hue_w;
    logic [hslc_pkg::LGT_W-1:0] negf_sum;
    hslc_pkg::t_sec             cfg_sec [NC];

    always_comb begin
        lp_pos   = !r_light[hslc_pkg::LGT_W-1] && (r_light != '0);
        lp_neg   = r_light[hslc_pkg::LGT_W-1];
        lp_mag   = (r_light > {1'b0, hslc_pkg::PCT_MAX}) ? hslc_pkg::PCT_MAX
                                                         : r_light[hslc_pkg::SAT_W-1:0];
        negf_sum = {1'b0, hslc_pkg::PCT_MAX} + r_light;
        lp_negf  = ($signed(r_light) < -$signed({1'b0, hslc_pkg::PCT_MAX})) ? '0
                                                         : negf_sum[hslc_pkg::SAT_W-1:0];
        sat_c    = (r_sat > hslc_pkg::PCT_MAX) ? hslc_pkg::PCT_MAX : r_sat;
        hue_w    = (r_hue >= hslc_pkg::DEG_FULL) ? (r_hue - hslc_pkg::DEG_FULL) : r_hue;
        cfg_sec[hslc_pkg::CH_RED] =
            hslc_pkg::hue_sector(hslc_pkg::hue_add(hue_w, hslc_pkg::DEG_120));
        cfg_sec[hslc_pkg::CH_GRN] = hslc_pkg::hue_sector(hue_w);
        cfg_sec[hslc_pkg::CH_BLU] =
            hslc_pkg::hue_sector(hslc_pkg::hue_add(hue_w, hslc_pkg::DEG_240));
    end

    // stage enables: a stage loads when it is empty or the next one loads
    logic [NS:1] r_vld;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !r_vld[NS] || !i_stall;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage data registers
    hslc_pkg::t_pix_in r1_pix, r2_pix, r3_pix, r4_pix, r5_pix, r6_pix, r7_pix;
    logic [LW-1:0]     r1_lum, r2_lum, r3_lum, r4_lum;
    logic [PW-1:0]     r1_prod, r3_prod;
    logic [LW-1:0]     r2_q, r4_q;
    logic              r3_low, r4_low;
    logic [LW-1:0]     r5_m1, r5_m2, r5_span;
    logic [LW-1:0]     r6_m1, r6_m2, r7_m1, r7_m2;
    logic [PW-1:0]     r6_prod [NC];
    logic [LW-1:0]     r7_q    [NC];
    hslc_pkg::t_sec_mode r6_mode [NC];
    hslc_pkg::t_sec_mode r7_mode [NC];
    hslc_pkg::t_pix_out  r_out;

    // combinational work between stages
    logic [LW-1:0]   n1_lum;
    logic [LW-1:0]   mul1_a;
    logic [6:0]      mul1_b;
    logic [23:0]     mul1_full;
    logic [46:0]     mul2_full;
    logic [LW-1:0]   n3_lum;
    logic            n3_low;
    logic [LW-1:0]   mul3_a;
    logic [7:0]      mul3_b;
    logic [24:0]     mul3_full;
    logic [46:0]     mul4_full;
    logic [LW:0]     m2_sum;
    logic [LW-1:0]   n5_m2;
    logic [LW:0]     m1_dif;
    logic [LW-1:0]   n5_m1;
    logic [PW-1:0]   mul6_full [NC];
    logic [45:0]     mul7_full [NC];
    logic [LW-1:0]   ch_val    [NC];
    logic [LW-1:0]   ramp      [NC];
    hslc_pkg::t_pix_out n8_out;

    always_comb begin
        // stage 1: intensity to luminance, start of the lightness product
        n1_lum = {1'b0, i_pix.intensity, i_pix.intensity}
               + LW'(i_pix.intensity != '0);
        if (lp_pos) begin
            mul1_a = hslc_pkg::ONE_Q16 - n1_lum;
            mul1_b = lp_mag;
        end else if (lp_neg) begin
            mul1_a = n1_lum;
            mul1_b = lp_negf;
        end else begin
            mul1_a = '0;
            mul1_b = '0;
        end
        mul1_full = {7'b0, mul1_a} * {17'b0, mul1_b};

        // stage 2: divide the lightness product by 100
        mul2_full = {24'b0, r1_prod} * {23'b0, hslc_pkg::RECIP_100};

        // stage 3: adjusted luminance, start of the m2 product
        if (lp_pos) begin
            n3_lum = r2_lum + r2_q;
        end else if (lp_neg) begin
            n3_lum = r2_q;
        end else begin
            n3_lum = r2_lum;
        end
        n3_low = (n3_lum <= hslc_pkg::HALF_Q16);
        if (n3_low) begin
            mul3_a = n3_lum;
            mul3_b = {1'b0, hslc_pkg::PCT_MAX} + {1'b0, sat_c};
        end else begin
            mul3_a = hslc_pkg::ONE_Q16 - n3_lum;
            mul3_b = {1'b0, sat_c};
        end
        mul3_full = {8'b0, mul3_a} * {17'b0, mul3_b};

        // stage 4: divide the m2 product by 100
        mul4_full = {24'b0, r3_prod} * {23'b0, hslc_pkg::RECIP_100};

        // stage 5: m2 with clamps, m1 and the span between them
        m2_sum = r4_low ? {1'b0, r4_q} : ({1'b0, r4_lum} + {1'b0, r4_q});
        if (m2_sum > {1'b0, hslc_pkg::ONE_Q16}) begin
            n5_m2 = hslc_pkg::ONE_Q16;
        end else begin
            n5_m2 = m2_sum[LW-1:0];
        end
        if (n5_m2 < r4_lum) begin
            n5_m2 = r4_lum;
        end
        m1_dif = {r4_lum, 1'b0} - {1'b0, n5_m2};
        n5_m1  = m1_dif[LW-1:0];

        // stages 6 to 8, one lane per colour
        for (int c = 0; c < NC; c++) begin
            mul6_full[c] = {6'b0, r5_span} * {17'b0, cfg_sec[c].wgt};
            mul7_full[c] = {23'b0, r6_prod[c]} * {23'b0, hslc_pkg::RECIP_60};
            ramp[c]      = r7_m1 + r7_q[c];
            unique case (r7_mode[c])
                hslc_pkg::SEC_RISE: ch_val[c] = ramp[c];
                hslc_pkg::SEC_FALL: ch_val[c] = ramp[c];
                hslc_pkg::SEC_HIGH: ch_val[c] = r7_m2;
                default:            ch_val[c] = r7_m1;
            endcase
        end

        // stage 8: bytes out, grey pass-through for low alpha
        n8_out.alpha_out = r7_pix.alpha_in;
        if (r7_pix.alpha_in < hslc_pkg::ALPHA_THRESHOLD) begin
            n8_out.red   = r7_pix.intensity;
            n8_out.green = r7_pix.intensity;
            n8_out.blue  = r7_pix.intensity;
        end else begin
            n8_out.red   = hslc_pkg::to_byte(ch_val[hslc_pkg::CH_RED]);
            n8_out.green = hslc_pkg::to_byte(ch_val[hslc_pkg::CH_GRN]);
            n8_out.blue  = hslc_pkg::to_byte(ch_val[hslc_pkg::CH_BLU]);
        end
    end

    // pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_pix  <= i_pix;
            r1_lum  <= n1_lum;
            r1_prod <= mul1_full[PW-1:0];
        end
        if (en[2]) begin
            r2_pix <= r1_pix;
            r2_lum <= r1_lum;
            r2_q   <= mul2_full[hslc_pkg::SHIFT_100+LW-1:hslc_pkg::SHIFT_100];
        end
        if (en[3]) begin
            r3_pix  <= r2_pix;
            r3_lum  <= n3_lum;
            r3_low  <= n3_low;
            r3_prod <= mul3_full[PW-1:0];
        end
        if (en[4]) begin
            r4_pix <= r3_pix;
            r4_lum <= r3_lum;
            r4_low <= r3_low;
            r4_q   <= mul4_full[hslc_pkg::SHIFT_100+LW-1:hslc_pkg::SHIFT_100];
        end
        if (en[5]) begin
            r5_pix  <= r4_pix;
            r5_m1   <= n5_m1;
            r5_m2   <= n5_m2;
            r5_span <= n5_m2 - n5_m1;
        end
        if (en[6]) begin
            r6_pix <= r5_pix;
            r6_m1  <= r5_m1;
            r6_m2  <= r5_m2;
            for (int c = 0; c < NC; c++) begin
                r6_prod[c] <= mul6_full[c];
                r6_mode[c] <= cfg_sec[c].mode;
            end
        end
        if (en[7]) begin
            r7_pix <= r6_pix;
            r7_m1  <= r6_m1;
            r7_m2  <= r6_m2;
            for (int c = 0; c < NC; c++) begin
                r7_q[c]    <= mul7_full[c][hslc_pkg::SHIFT_60+LW-1:hslc_pkg::SHIFT_60];
                r7_mode[c] <= r6_mode[c];
            end
        end
        if (en[8]) begin
            r_out <= n8_out;
        end
    end

    assign o_pix = r_out;

    // low-alpha results are always grey
    a_low_alpha_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pix.alpha_out < hslc_pkg::ALPHA_THRESHOLD))
        |-> (o_pix.red == o_pix.green && o_pix.green == o_pix.blue))
        else $error("low-alpha pixel is not grey");

    // input stall only when the whole pipe is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld && i_stall))
        else $error("input stalled with room in the pipeline");

    // a pixel blocked in stage seven stays there
    a_hold_stage7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && !en[NS]) |=> r_vld[NS-1])
        else $error("pixel lost in stage seven under stall");

    // the hue band never inverts
    a_m2_ge_m1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r5_m2 >= r5_m1 && r5_span == r5_m2 - r5_m1))
        else $error("m2 below m1");

endmodule

`default_nettype wire
